[rtl/blit_raster_op_16bpp_assert.svh]
// ---------------------------------------------------------------------------
// blit assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef BLIT_RASTER_OP_16BPP_ASSERT_SVH
`define BLIT_RASTER_OP_16BPP_ASSERT_SVH

// property must hold at every rising clock edge out of reset
`define BLIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a rising clock edge out of reset
`define BLIT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/blit_pkg.sv]
// ---------------------------------------------------------------------------
// blit_pkg
// shared constants, codes, item types and the raster function of the blitter
// ---------------------------------------------------------------------------
package blit_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned OUT_ADDR_W    = 32;
  localparam int unsigned DIM_REG_W     = 13;
  localparam int unsigned PITCH_W       = 15;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned ADDR_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ROP_ONES   = 4'd0,
    ROP_AND    = 4'd1,
    ROP_AND_ND = 4'd2,
    ROP_SRC    = 4'd3,
    ROP_NS_AND = 4'd4,
    ROP_DST    = 4'd5,
    ROP_XOR    = 4'd6,
    ROP_OR     = 4'd7,
    ROP_NOR    = 4'd8,
    ROP_XNOR   = 4'd9,
    ROP_ND     = 4'd10,
    ROP_OR_ND  = 4'd11,
    ROP_NS     = 4'd12,
    ROP_NS_OR  = 4'd13,
    ROP_NAND   = 4'd14,
    ROP_ZEROS  = 4'd15
  } rop_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROP       = 3'd0,
    CFG_BACKWARD  = 3'd1,
    CFG_WIDTH     = 3'd2,
    CFG_HEIGHT    = 3'd3,
    CFG_SRC_START = 3'd4,
    CFG_SRC_PITCH = 3'd5,
    CFG_DST_START = 3'd6,
    CFG_DST_PITCH = 3'd7
  } cfg_idx_e;

  // pixel pair with the position it was read at
  typedef struct packed {
    logic [PIX_W-1:0]      src_pixel;
    logic [PIX_W-1:0]      dst_pixel;
    logic [OUT_ADDR_W-1:0] src_addr;
    logic [OUT_ADDR_W-1:0] dst_addr;
    logic                  last;
  } pix_item_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] src_addr;
    logic [OUT_ADDR_W-1:0] dst_addr;
    logic [PIX_W-1:0]      new_pixel;
    logic                  write_enable;
    logic                  last;
  } res_item_t;

  function automatic logic [PIX_W-1:0] raster(rop_e mode, logic [PIX_W-1:0] s,
                                              logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] r;
    case (mode)
      ROP_ONES:   r = '1;
      ROP_AND:    r = s & d;
      ROP_AND_ND: r = s & ~d;
      ROP_SRC:    r = s;
      ROP_NS_AND: r = ~s & d;
      ROP_DST:    r = d;
      ROP_XOR:    r = s ^ d;
      ROP_OR:     r = s | d;
      ROP_NOR:    r = ~(s | d);
      ROP_XNOR:   r = ~(s ^ d);
      ROP_ND:     r = ~d;
      ROP_OR_ND:  r = s | ~d;
      ROP_NS:     r = ~s;
      ROP_NS_OR:  r = ~s | d;
      ROP_NAND:   r = ~(s & d);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/blit_walk.sv]
// ---------------------------------------------------------------------------
// blit_walk
// rectangle walker: column and row counters with running source and
// destination addresses, one step per accepted item
// ---------------------------------------------------------------------------
`include "blit_raster_op_16bpp_assert.svh"

module blit_walk #(
  parameter int unsigned MAX_DIM   = blit_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_BITS = blit_pkg::ADDR_BITS_DEF,
  parameter int unsigned CW        = $clog2(MAX_DIM)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          adv_i,
  input  logic                          backward_i,
  input  logic [CW-1:0]                 w_last_i,
  input  logic [CW-1:0]                 h_last_i,
  input  logic [ADDR_BITS-1:0]          src_start_i,
  input  logic [ADDR_BITS-1:0]          dst_start_i,
  input  logic [blit_pkg::PITCH_W-1:0]  src_pitch_i,
  input  logic [blit_pkg::PITCH_W-1:0]  dst_pitch_i,
  output logic [ADDR_BITS-1:0]          src_addr_o,
  output logic [ADDR_BITS-1:0]          dst_addr_o,
  output logic                          last_o
);
  import blit_pkg::*;

  logic [CW-1:0]        col_q, col_d, row_q, row_d;
  logic                 fresh_q, fresh_d;
  logic [ADDR_BITS-1:0] src_cur_q, src_cur_d, src_base_q, src_base_d;
  logic [ADDR_BITS-1:0] dst_cur_q, dst_cur_d, dst_base_q, dst_base_d;
  logic [ADDR_BITS-1:0] src_row, dst_row, src_next_row, dst_next_row;
  logic [ADDR_BITS-1:0] src_next_col, dst_next_col, src_px, dst_px;
  logic                 end_row;

  // fresh: walk sits at the first pixel, addresses come from the start regs
  assign src_addr_o = fresh_q ? src_start_i : src_cur_q;
  assign dst_addr_o = fresh_q ? dst_start_i : dst_cur_q;
  assign src_row    = fresh_q ? src_start_i : src_base_q;
  assign dst_row    = fresh_q ? dst_start_i : dst_base_q;

  assign src_px = ADDR_BITS'(src_pitch_i);
  assign dst_px = ADDR_BITS'(dst_pitch_i);

  assign src_next_row = backward_i ? src_row - src_px : src_row + src_px;
  assign dst_next_row = backward_i ? dst_row - dst_px : dst_row + dst_px;
  assign src_next_col = backward_i ? src_addr_o - ADDR_BITS'(2) : src_addr_o + ADDR_BITS'(2);
  assign dst_next_col = backward_i ? dst_addr_o - ADDR_BITS'(2) : dst_addr_o + ADDR_BITS'(2);

  assign end_row = (col_q == w_last_i);
  assign last_o  = end_row && (row_q == h_last_i);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    fresh_d    = fresh_q;
    src_cur_d  = src_cur_q;
    dst_cur_d  = dst_cur_q;
    src_base_d = src_base_q;
    dst_base_d = dst_base_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      fresh_d = 1'b1;
    end else if (adv_i) begin
      if (last_o) begin
        col_d   = '0;
        row_d   = '0;
        fresh_d = 1'b1;
      end else if (end_row) begin
        col_d      = '0;
        row_d      = row_q + CW'(1);
        fresh_d    = 1'b0;
        src_cur_d  = src_next_row;
        dst_cur_d  = dst_next_row;
        src_base_d = src_next_row;
        dst_base_d = dst_next_row;
      end else begin
        col_d      = col_q + CW'(1);
        fresh_d    = 1'b0;
        src_cur_d  = src_next_col;
        dst_cur_d  = dst_next_col;
        src_base_d = src_row;
        dst_base_d = dst_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      fresh_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_cur_q  <= src_cur_d;
    dst_cur_q  <= dst_cur_d;
    src_base_q <= src_base_d;
    dst_base_q <= dst_base_d;
  end

  `BLIT_ASSERT_NEVER(a_col_in_row, col_q > w_last_i, "column counter ran past the row end")
  `BLIT_ASSERT_NEVER(a_row_in_rect, row_q > h_last_i, "row counter ran past the last row")
  `BLIT_ASSERT(a_last_restarts, (adv_i && last_o && !restart_i) |=> (fresh_q && col_q == '0 && row_q == '0), "walk did not restart after the last pixel")

endmodule

[rtl/blit_out.sv]
// ---------------------------------------------------------------------------
// blit_out
// raster operation and result register with stream handshake
// ---------------------------------------------------------------------------
module blit_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  blit_pkg::pix_item_t  in_item_i,
  input  blit_pkg::rop_e       rop_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output blit_pkg::res_item_t  out_item_o,
  input  logic                 out_ready_i
);
  import blit_pkg::*;

  logic      valid_q, valid_d, load;
  res_item_t item_q, item_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    item_d.src_addr     = in_item_i.src_addr;
    item_d.dst_addr     = in_item_i.dst_addr;
    item_d.new_pixel    = raster(rop_i, in_item_i.src_pixel, in_item_i.dst_pixel);
    item_d.write_enable = (rop_i != ROP_DST);
    item_d.last         = in_item_i.last;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/blit_raster_op_16bpp.sv]
// ---------------------------------------------------------------------------
// blit_raster_op_16bpp
// rectangle blitter for 16-bit pixels with the sixteen raster operations
//
//   channel  direction  payload
//   s_*      in         tdata: src_pixel, dst_pixel
//   m_*      out        tdata: src_addr, dst_addr, new_pixel; tuser: write_enable;
//                       tlast: last_pixel
//   cfg_*    in         cfg_index_i selects the register, cfg_data_i is written
//
// one item per cycle while m_tready_i is high; from s accept to m valid an item passes
// through the input register, then raster logic into the result register
// the walk counters step on every s accept, the address update is one add
// reset leaves the walk at the first pixel with mode copy source, 1x1 rect
// a stall on m holds the result register and then the input register;
// s_tready_o drops only when both are full and m_tready_i is low
// cfg_ready_o is always high, every write restarts the walk
// ---------------------------------------------------------------------------
`include "blit_raster_op_16bpp_assert.svh"

module blit_raster_op_16bpp #(
  parameter int unsigned MAX_DIM   = blit_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_BITS = blit_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [2*blit_pkg::PIX_W-1:0]      s_tdata_i,  // src_pixel, dst_pixel
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // src_addr, dst_addr, new_pixel
  output logic [2*blit_pkg::OUT_ADDR_W+blit_pkg::PIX_W-1:0] m_tdata_o,
  output logic                              m_tuser_o,  // write_enable
  output logic                              m_tlast_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [blit_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [blit_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import blit_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_DIM);
  localparam int unsigned WIDE_W = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

  // configuration registers
  rop_e                  rop_q;
  logic                  back_q;
  logic [CW-1:0]         w_last_q, h_last_q, dim_last;
  logic [OUT_ADDR_W-1:0] src_start_q, dst_start_q;
  logic [PITCH_W-1:0]    src_pitch_q, dst_pitch_q;
  logic [31:0]           dim_v;
  logic                  cfg_acc;

  // walker and pipeline
  logic [ADDR_BITS-1:0]  walk_src, walk_dst;
  logic [WIDE_W-1:0]     src_wide, dst_wide;
  logic                  walk_last, s_acc, out_in_ready;
  logic                  a_valid_q, a_valid_d;
  pix_item_t             a_item_q, a_item_d;
  res_item_t             res;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  // zero reads as one, anything past MAX_DIM saturates
  assign dim_v    = 32'(cfg_data_i[DIM_REG_W-1:0]);
  assign dim_last = (dim_v == 32'd0) ? '0 :
                    (dim_v > 32'(MAX_DIM)) ? CW'(MAX_DIM - 1) : CW'(dim_v - 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rop_q       <= ROP_SRC;
      back_q      <= 1'b0;
      w_last_q    <= '0;
      h_last_q    <= '0;
      src_start_q <= '0;
      src_pitch_q <= '0;
      dst_start_q <= '0;
      dst_pitch_q <= '0;
    end else if (cfg_acc) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROP:       rop_q       <= rop_e'(cfg_data_i[3:0]);
        CFG_BACKWARD:  back_q      <= cfg_data_i[0];
        CFG_WIDTH:     w_last_q    <= dim_last;
        CFG_HEIGHT:    h_last_q    <= dim_last;
        CFG_SRC_START: src_start_q <= cfg_data_i[OUT_ADDR_W-1:0];
        CFG_SRC_PITCH: src_pitch_q <= cfg_data_i[PITCH_W-1:0];
        CFG_DST_START: dst_start_q <= cfg_data_i[OUT_ADDR_W-1:0];
        CFG_DST_PITCH: dst_pitch_q <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  blit_walk #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS),
    .CW        (CW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_acc),
    .adv_i       (s_acc),
    .backward_i  (back_q),
    .w_last_i    (w_last_q),
    .h_last_i    (h_last_q),
    .src_start_i (ADDR_BITS'(WIDE_W'(src_start_q))),
    .dst_start_i (ADDR_BITS'(WIDE_W'(dst_start_q))),
    .src_pitch_i (src_pitch_q),
    .dst_pitch_i (dst_pitch_q),
    .src_addr_o  (walk_src),
    .dst_addr_o  (walk_dst),
    .last_o      (walk_last)
  );

  // input register, refills in the same cycle it drains
  assign s_tready_o = !a_valid_q || out_in_ready;
  assign s_acc      = s_tvalid_i && s_tready_o;

  assign src_wide = WIDE_W'(walk_src);
  assign dst_wide = WIDE_W'(walk_dst);

  always_comb begin
    a_item_d.src_pixel = s_tdata_i[PIX_W-1:0];
    a_item_d.dst_pixel = s_tdata_i[2*PIX_W-1:PIX_W];
    a_item_d.src_addr  = src_wide[OUT_ADDR_W-1:0];
    a_item_d.dst_addr  = dst_wide[OUT_ADDR_W-1:0];
    a_item_d.last      = walk_last;
    if (s_acc) begin
      a_valid_d = 1'b1;
    end else if (out_in_ready) begin
      a_valid_d = 1'b0;
    end else begin
      a_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_item_q <= a_item_d;
    end
  end

  blit_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid_q),
    .in_item_i   (a_item_q),
    .rop_i       (rop_q),
    .in_ready_o  (out_in_ready),
    .out_valid_o (m_tvalid_o),
    .out_item_o  (res),
    .out_ready_i (m_tready_i)
  );

  assign m_tdata_o = {res.new_pixel, res.dst_addr, res.src_addr};
  assign m_tuser_o = res.write_enable;
  assign m_tlast_o = res.last;

  `BLIT_ASSERT(a_hold_input, (a_valid_q && !out_in_ready) |=> (a_valid_q && $stable(a_item_q)), "input register lost or changed a stalled item")
  `BLIT_ASSERT(a_empty_ready, !a_valid_q |-> s_tready_o, "input side stalled with an empty input register")
  `BLIT_ASSERT(a_drain_to_out, (a_valid_q && out_in_ready) |=> m_tvalid_o, "item left the input register without reaching the result register")

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the 16bpp raster-op blitter: a directed table
// (reset state, every raster op, degenerate and saturated sizes, walk restart,
// backward address wrap) and then randomized walks of random shape, with
// random stalls on both streams, checked item by item against a predictor
// ---------------------------------------------------------------------------
module tb_top;
  import blit_pkg::*;

  localparam int unsigned TOTAL_PIXELS = 1450;
  localparam int unsigned QUIET_FROM   = 1250;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned HOLD_PHASE   = 4;
  localparam int unsigned DIM_CAP      = 4096;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] src_addr;
    logic [OUT_ADDR_W-1:0] dst_addr;
    logic [PIX_W-1:0]      new_pixel;
    logic                  write_enable;
    logic                  last_pixel;
  } pixel_write_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         idx;
    logic [31:0]      value;
    logic [PIX_W-1:0] src_pix;
    logic [PIX_W-1:0] dst_pix;
    bit               fixed;
    pixel_write_t     want;
  } stim_row_t;

  logic                                    clk_i = 1'b0;
  logic                                    rst_ni;
  logic                                    s_tvalid_i;
  logic                                    s_tready_o;
  logic [2*PIX_W-1:0]                      s_tdata_i;
  logic                                    m_tvalid_o;
  logic                                    m_tready_i;
  logic [2*OUT_ADDR_W+PIX_W-1:0]           m_tdata_o;
  logic                                    m_tuser_o;
  logic                                    m_tlast_o;
  logic                                    cfg_valid_i;
  logic                                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]                    cfg_index_i;
  logic [CFG_DATA_W-1:0]                   cfg_data_i;

  // walk predictor: register copy and walk position
  rop_e                 cfg_rop;
  logic                 cfg_backward;
  logic [DIM_REG_W-1:0] cfg_width;
  logic [DIM_REG_W-1:0] cfg_height;
  logic [31:0]          cfg_src_start;
  logic [31:0]          cfg_dst_start;
  logic [PITCH_W-1:0]   cfg_src_pitch;
  logic [PITCH_W-1:0]   cfg_dst_pitch;
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [31:0]          src_row_off;
  logic [31:0]          dst_row_off;

  pixel_write_t expected_writes[$];
  stim_row_t    stim_rows[$];
  int unsigned  mismatches   = 0;
  int unsigned  pixels_sent  = 0;
  bit           idle_on      = 1'b1;
  bit           hold_off_req = 1'b0;

  blit_raster_op_16bpp DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void restart_walk_model();
    col_cnt     = 0;
    row_cnt     = 0;
    src_row_off = '0;
    dst_row_off = '0;
  endfunction

  // zero counts as one, anything past the cap saturates
  function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rop_result(rop_e mode, logic [PIX_W-1:0] s,
                                                  logic [PIX_W-1:0] d);
    case (mode)
      ROP_ONES:   return 16'hffff;
      ROP_AND:    return s & d;
      ROP_AND_ND: return s & ~d;
      ROP_SRC:    return s;
      ROP_NS_AND: return ~s & d;
      ROP_DST:    return d;
      ROP_XOR:    return s ^ d;
      ROP_OR:     return s | d;
      ROP_NOR:    return ~(s | d);
      ROP_XNOR:   return ~(s ^ d);
      ROP_ND:     return ~d;
      ROP_OR_ND:  return s | ~d;
      ROP_NS:     return ~s;
      ROP_NS_OR:  return ~s | d;
      ROP_NAND:   return ~(s & d);
      default:    return 16'h0000;
    endcase
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] v);
    case (idx)
      CFG_ROP:       cfg_rop = rop_e'(v[3:0]);
      CFG_BACKWARD:  cfg_backward = v[0];
      CFG_WIDTH:     cfg_width = v[DIM_REG_W-1:0];
      CFG_HEIGHT:    cfg_height = v[DIM_REG_W-1:0];
      CFG_SRC_START: cfg_src_start = v;
      CFG_SRC_PITCH: cfg_src_pitch = v[PITCH_W-1:0];
      CFG_DST_START: cfg_dst_start = v;
      CFG_DST_PITCH: cfg_dst_pitch = v[PITCH_W-1:0];
      default: ;
    endcase
    restart_walk_model();
  endfunction

  function automatic pixel_write_t step_walk(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d);
    pixel_write_t r;
    int unsigned  w;
    int unsigned  h;
    logic [31:0]  col_bytes;
    bit           end_row;
    bit           last;
    w         = eff_dim(cfg_width);
    h         = eff_dim(cfg_height);
    col_bytes = 32'(col_cnt * 2);
    end_row   = col_cnt >= w - 1;
    last      = end_row && row_cnt >= h - 1;
    if (cfg_backward) begin
      r.src_addr = cfg_src_start + src_row_off - col_bytes;
      r.dst_addr = cfg_dst_start + dst_row_off - col_bytes;
    end else begin
      r.src_addr = cfg_src_start + src_row_off + col_bytes;
      r.dst_addr = cfg_dst_start + dst_row_off + col_bytes;
    end
    r.new_pixel    = rop_result(cfg_rop, s, d);
    r.write_enable = (cfg_rop != ROP_DST);
    r.last_pixel   = last;
    if (last) begin
      restart_walk_model();
    end else if (end_row) begin
      col_cnt = 0;
      row_cnt++;
      if (cfg_backward) begin
        src_row_off = src_row_off - 32'(cfg_src_pitch);
        dst_row_off = dst_row_off - 32'(cfg_dst_pitch);
      end else begin
        src_row_off = src_row_off + 32'(cfg_src_pitch);
        dst_row_off = dst_row_off + 32'(cfg_dst_pitch);
      end
    end else begin
      col_cnt++;
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [31:0] value);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.idx     = idx;
    row.value   = value;
    row.src_pix = '0;
    row.dst_pix = '0;
    row.fixed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_pix(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d, bit fixed,
                                  pixel_write_t want);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.idx     = CFG_ROP;
    row.value   = '0;
    row.src_pix = s;
    row.dst_pix = d;
    row.fixed   = fixed;
    row.want    = want;
    stim_rows.push_back(row);
  endfunction

  task automatic push_pixel(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d, bit fixed,
                            pixel_write_t want);
    pixel_write_t pred;
    int unsigned  gap;
    gap = 0;
    if (idle_on && !hold_off_req && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {d, s};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    pred = step_walk(s, d);
    expected_writes.push_back(fixed ? want : pred);
    pixels_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // first phase takes every register to its top, second to its bottom
  task automatic setup_walk(int unsigned phase);
    logic [31:0] v [8];
    bit          big;
    big = ($urandom_range(0, 11) == 0);
    if (phase == 0) begin
      v = '{32'(ROP_ZEROS), 32'h1, 32'(DIM_CAP), 32'(DIM_CAP), 32'hffff_ffff, 32'h7fff,
            32'hffff_ffff, 32'h7fff};
    end else if (phase == 1) begin
      v = '{32'(ROP_ONES), 32'h0, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0};
    end else begin
      foreach (v[i]) v[i] = $urandom();
      v[CFG_WIDTH][DIM_REG_W-1:0]  = big ? 13'($urandom_range(0, 8191))
                                         : 13'($urandom_range(0, 9));
      v[CFG_HEIGHT][DIM_REG_W-1:0] = big ? 13'($urandom_range(0, 8191))
                                         : 13'($urandom_range(0, 6));
      // push starts near the ends of the address space so walks wrap
      case ($urandom_range(0, 3))
        0: v[CFG_SRC_START] = $urandom_range(0, 64);
        1: v[CFG_SRC_START] = 32'hffff_ffff - $urandom_range(0, 64);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: v[CFG_DST_START] = $urandom_range(0, 64);
        1: v[CFG_DST_START] = 32'hffff_ffff - $urandom_range(0, 64);
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: v[CFG_SRC_PITCH][PITCH_W-1:0] = '0;
        1: v[CFG_SRC_PITCH][PITCH_W-1:0] = '1;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: v[CFG_DST_PITCH][PITCH_W-1:0] = '0;
        1: v[CFG_DST_PITCH][PITCH_W-1:0] = '1;
        default: ;
      endcase
    end
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), v[i]);
  endtask

  initial begin : stimulus
    rop_e        op_list [12];
    int unsigned phase;
    int unsigned n;
    int unsigned walk_len;
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROP;
    cfg_data_i  = '0;

    cfg_rop       = ROP_SRC;
    cfg_backward  = 1'b0;
    cfg_width     = 13'd1;
    cfg_height    = 13'd1;
    cfg_src_start = '0;
    cfg_dst_start = '0;
    cfg_src_pitch = '0;
    cfg_dst_pitch = '0;
    restart_walk_model();

    // reset state: copy source over a 1x1 rectangle at address zero
    add_pix(16'h1234, 16'habcd, 1'b1, {32'h0, 32'h0, 16'h1234, 1'b1, 1'b1});
    add_pix(16'hffff, 16'h0000, 1'b1, {32'h0, 32'h0, 16'hffff, 1'b1, 1'b1});
    add_cfg(CFG_ROP, ROP_ONES);
    add_pix(16'h0000, 16'h0000, 1'b1, {32'h0, 32'h0, 16'hffff, 1'b1, 1'b1});
    add_cfg(CFG_ROP, ROP_ZEROS);
    add_pix(16'hffff, 16'hffff, 1'b1, {32'h0, 32'h0, 16'h0000, 1'b1, 1'b1});
    // destination only: pixel passes through, no write
    add_cfg(CFG_ROP, ROP_DST);
    add_pix(16'h5555, 16'haaaa, 1'b1, {32'h0, 32'h0, 16'haaaa, 1'b0, 1'b1});
    op_list = '{ROP_AND, ROP_AND_ND, ROP_NS_AND, ROP_XOR, ROP_OR, ROP_NOR, ROP_XNOR,
                ROP_ND, ROP_OR_ND, ROP_NS, ROP_NS_OR, ROP_NAND};
    foreach (op_list[k]) begin
      add_cfg(CFG_ROP, op_list[k]);
      add_pix(16'h0ff0, 16'h3c3c, 1'b0, '0);
    end
    // zero width and height behave as 1x1
    add_cfg(CFG_WIDTH, 32'h0);
    add_cfg(CFG_HEIGHT, 32'h0);
    add_pix(16'h0000, 16'h0000, 1'b1, {32'h0, 32'h0, 16'hffff, 1'b1, 1'b1});
    // oversized dims saturate, upper data bits ignored
    add_cfg(CFG_WIDTH, 32'hffff_ffff);
    add_cfg(CFG_HEIGHT, 32'h0000_1001);
    add_pix(16'h8001, 16'h7ffe, 1'b0, '0);
    add_pix(16'h7ffe, 16'h8001, 1'b0, '0);
    // a write in the middle of a row restarts the walk
    add_cfg(CFG_WIDTH, 32'h3);
    add_cfg(CFG_HEIGHT, 32'h2);
    add_pix(16'h1111, 16'h2222, 1'b0, '0);
    add_cfg(CFG_SRC_PITCH, 32'h40);
    add_pix(16'h3333, 16'h4444, 1'b0, '0);
    // backward walk from the bottom of the address space wraps around
    add_cfg(CFG_BACKWARD, 32'h1);
    add_cfg(CFG_DST_START, 32'h2);
    add_cfg(CFG_DST_PITCH, 32'h7fff);
    add_cfg(CFG_WIDTH, 32'h2);
    repeat (4) add_pix(rand_pixel(), rand_pixel(), 1'b0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain_results();
        write_reg(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        push_pixel(stim_rows[i].src_pix, stim_rows[i].dst_pix, stim_rows[i].fixed,
                   stim_rows[i].want);
      end
    end

    phase = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      drain_results();
      setup_walk(phase);
      walk_len = eff_dim(cfg_width) * eff_dim(cfg_height);
      if (walk_len <= 48) begin
        n = walk_len * $urandom_range(1, 3);
        // sometimes stop partway through a rectangle
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, walk_len);
      end else begin
        n = $urandom_range(10, 40);
      end
      if (phase == HOLD_PHASE) begin
        hold_off_req = 1'b1;
        n = 30;
      end
      repeat (n) begin
        if (pixels_sent >= QUIET_FROM) idle_on = 1'b0;
        push_pixel(rand_pixel(), rand_pixel(), 1'b0, '0);
      end
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("blit_raster_op_16bpp verification clean");
    end else begin
      $display("blit_raster_op_16bpp verification failed");
    end
    $finish;
  end

  // result side: random stall bursts, plus one long hold so the pipe backs up
  initial begin : sink_pace
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_writes
    pixel_write_t got;
    pixel_write_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = {m_tdata_o[31:0], m_tdata_o[63:32], m_tdata_o[79:64], m_tuser_o, m_tlast_o};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected item src %h dst %h pix %h we %b last %b", $realtime,
                   got.src_addr, got.dst_addr, got.new_pixel, got.write_enable,
                   got.last_pixel);
      end else begin
        want = expected_writes.pop_front();
        if (got.src_addr !== want.src_addr || got.dst_addr !== want.dst_addr ||
            got.new_pixel !== want.new_pixel || got.write_enable !== want.write_enable ||
            got.last_pixel !== want.last_pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: item mismatch, want src %h dst %h pix %h we %b last %b,%s",
                     $realtime, want.src_addr, want.dst_addr, want.new_pixel,
                     want.write_enable, want.last_pixel,
                     $sformatf(" got src %h dst %h pix %h we %b last %b", got.src_addr,
                               got.dst_addr, got.new_pixel, got.write_enable,
                               got.last_pixel));
        end
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("blit_raster_op_16bpp verification failed");
    $finish;
  end

endmodule
